### rtl/core/itoa_pkg.sv
// shared types, constants and glyph table for the integer to ascii radix block
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IN_BITS    = 32;
    localparam int VAL_W      = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
    localparam int DEPTH      = VAL_W;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);

    localparam logic [1:0] MODE_BIN = 2'd0;
    localparam logic [1:0] MODE_OCT = 2'd1;
    localparam logic [1:0] MODE_DEC = 2'd2;
    localparam logic [1:0] MODE_HEX = 2'd3;

    // q = (v * DEC_RECIP) >> DEC_SHIFT is exact v / 10 for v below 2**32
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    localparam logic [7:0] GLYPH [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [IN_BITS-1:0] value;
        logic [1:0]         mode;
    } t_in_item;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic mul;
        logic digit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_dec;
        logic dig_last;
        logic rd_last;
    } t_sts;

endpackage

### rtl/core/integer_to_ascii_radix_top.sv
// Converts an unsigned integer to upper-case ASCII digits in binary, octal, decimal
// or hexadecimal, most significant digit first, last digit flagged. One item is
// worked at a time: a load step, then for binary, octal and hexadecimal one spare
// multiply step and one step per digit, or for decimal a 32x32 reciprocal multiply
// followed by the remainder step for each digit, then the digits are emitted from
// the digit store into the output register while the output is not stalled. The
// next item is taken once the last digit has entered the output register.
module integer_to_ascii_radix_top
    import itoa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd cmd;
    t_sts sts;

    itoa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    itoa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

### rtl/core/itoa_dp.sv
// datapath: value register, reciprocal multiplier, digit store and output register
module itoa_dp
    import itoa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_data,
    output t_sts      o_sts,
    output t_out_item o_out_data
);

    logic [VAL_W-1:0] r_val;
    logic [1:0]       r_mode;
    logic [63:0]      r_prod;
    logic [3:0]       r_store [DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_rd;
    t_out_item        r_out;

    logic [31:0]      mul_a;
    logic [63:0]      n_prod;
    logic [VAL_W-1:0] dec_q;
    logic [VAL_W-1:0] dec_rem;
    logic [VAL_W-1:0] quot;
    logic [3:0]       digit;
    logic             dig_last;

    assign mul_a  = 32'(r_val);
    assign n_prod = mul_a * DEC_RECIP;
    assign dec_q  = VAL_W'(r_prod >> DEC_SHIFT);
    assign dec_rem = r_val - ((dec_q << 3) + (dec_q << 1));

    always_comb begin
        unique case (r_mode)
            MODE_BIN: begin
                quot  = r_val >> 1;
                digit = {3'd0, r_val[0]};
            end
            MODE_OCT: begin
                quot  = r_val >> 3;
                digit = {1'b0, r_val[2:0]};
            end
            MODE_DEC: begin
                quot  = dec_q;
                digit = dec_rem[3:0];
            end
            default: begin
                quot  = r_val >> 4;
                digit = r_val[3:0];
            end
        endcase
    end

    assign dig_last = (quot == '0) || (r_cnt == CNT_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.digit) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (dig_last) begin
                r_rd <= r_cnt[IDX_W-1:0];
            end
        end else if (i_cmd.emit) begin
            r_rd <= r_rd - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_in_data.value[VAL_W-1:0];
            r_mode <= i_in_data.mode;
        end else if (i_cmd.digit) begin
            r_val <= quot;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.digit) begin
            r_store[r_cnt[IDX_W-1:0]] <= digit;
        end
        if (i_cmd.emit) begin
            r_out.ascii_char <= GLYPH[r_store[r_rd]];
            r_out.last       <= (r_rd == '0);
        end
    end

    assign o_sts.is_dec   = (r_mode == MODE_DEC);
    assign o_sts.dig_last = dig_last;
    assign o_sts.rd_last  = (r_rd == '0);
    assign o_out_data     = r_out;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("digit count beyond store depth");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (CNT_W'(r_rd) < r_cnt))
        else $error("read index beyond written digits");

    a_load_clears_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cnt == '0))
        else $error("digit count not cleared by load");
`endif

endmodule

### rtl/core/itoa_ctrl.sv
// controller: sequences load, divide steps and digit output
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIG  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;
    logic       out_free;

    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // every item starts with a multiply; the mode is known only after load
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIG;
            end
            S_DIG: begin
                o_cmd.digit = 1'b1;
                if (i_sts.dig_last) begin
                    n_state = S_EMIT;
                end else if (i_sts.is_dec) begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

`ifndef ASSERT_OFF
    a_load_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_MUL))
        else $error("accepted item did not start digit work");

    a_dig_done_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.digit && i_sts.dig_last) |=> (r_state == S_EMIT))
        else $error("last digit step did not enter output phase");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.rd_last) |=> (r_state == S_IDLE) && r_ovalid)
        else $error("final digit did not return to idle with item shown");

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !(r_ovalid && i_out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule
